// ===== hw/rtl/csa_pkg.sv =====
// Package for the Cartesian to spherical angles block.
// Holds the CORDIC arctangent table and the shared widths; no dependencies.
package csa_pkg;

  localparam int unsigned CoordWidthDef  = 16;
  localparam int unsigned AngleWidthDef  = 16;
  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned Guard          = 28;
  localparam int unsigned DpWidth        = 62;
  localparam int unsigned SqrtSteps      = 4;

  localparam logic [31:0] HalfTurn    = 32'h8000_0000;
  localparam logic [31:0] QuarterTurn = 32'h4000_0000;

  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] r;
    r = '0;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] to_angle(input logic [31:0] a, input int unsigned aw);
    logic [32:0] s;
    s = {1'b0, a};
    if (aw < 32) begin
      s = (s + (33'd1 << (31 - aw))) >> (32 - aw);
    end
    return s[31:0];
  endfunction

endpackage

// ===== hw/rtl/csa_cordic.sv =====
// Pipelined first-quadrant CORDIC vectoring unit, one register per iteration.
// Uses csa_pkg for the arctangent table and the datapath width.
module csa_cordic #(
  parameter int unsigned STAGES = csa_pkg::CordicStagesDef,
  parameter int unsigned TAG_W  = 8
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [31:0]       a_i,
  input  logic [31:0]       b_i,
  input  logic [TAG_W-1:0]  tag_i,
  output logic [31:0]       ang_o,
  output logic [TAG_W-1:0]  tag_o
);

  localparam int unsigned W = csa_pkg::DpWidth + 2;

  logic signed [W-1:0] px_q [STAGES+1];
  logic signed [W-1:0] py_q [STAGES+1];
  logic signed [35:0]  acc_q [STAGES+1];
  logic                zero_q [STAGES+1];
  logic [TAG_W-1:0]    tag_q [STAGES+1];

  always_comb begin
    px_q[0]   = W'({a_i, 28'd0});
    py_q[0]   = W'({b_i, 28'd0});
    acc_q[0]  = '0;
    zero_q[0] = (a_i == '0) && (b_i == '0);
    tag_q[0]  = tag_i;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic [4:0] K = 5'(i % 32);
    logic signed [W-1:0] sx, sy;
    assign sx = px_q[i] >>> K;
    assign sy = py_q[i] >>> K;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (py_q[i] >= 0) begin
          px_q[i+1]  <= px_q[i] + sy;
          py_q[i+1]  <= py_q[i] - sx;
          acc_q[i+1] <= acc_q[i] + 36'(csa_pkg::atan_lut(K));
        end else begin
          px_q[i+1]  <= px_q[i] - sy;
          py_q[i+1]  <= py_q[i] + sx;
          acc_q[i+1] <= acc_q[i] - 36'(csa_pkg::atan_lut(K));
        end
        zero_q[i+1] <= zero_q[i];
        tag_q[i+1]  <= tag_q[i];
      end
    end
  end

  always_comb begin
    if (zero_q[STAGES] || acc_q[STAGES] < 0) begin
      ang_o = '0;
    end else if (acc_q[STAGES] > 36'(csa_pkg::QuarterTurn)) begin
      ang_o = csa_pkg::QuarterTurn;
    end else begin
      ang_o = acc_q[STAGES][31:0];
    end
  end
  assign tag_o = tag_q[STAGES];

endmodule

// ===== hw/rtl/cartesian_to_spherical_angles.sv =====
// Cartesian to spherical angles: azimuth and polar angle of a Q2.14 point.
// The pipeline is a magnitude stage, a squaring and shift stage, 32 integer
// square root steps, an operand register, one CORDIC iteration per stage and an output register.
// Throughput is one beat per cycle; a stall freezes the whole pipeline.
// Reset clears only the valid bits; data registers are not reset.
// Depends on csa_pkg and csa_cordic.
module cartesian_to_spherical_angles #(
  parameter int unsigned COORD_WIDTH   = csa_pkg::CoordWidthDef,
  parameter int unsigned ANGLE_WIDTH   = csa_pkg::AngleWidthDef,
  parameter int unsigned CORDIC_STAGES = csa_pkg::CordicStagesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // x_coord, y_coord, z_coord from the lowest bit up.
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // azimuth, polar from the lowest bit up.
  output logic [((2*ANGLE_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned LSH = (CW < 31) ? 31 - CW : 0;
  localparam int unsigned SQ  = 32;
  localparam int unsigned LAT = SQ + 3 + CORDIC_STAGES;
  localparam int unsigned OUTW = ((2*ANGLE_WIDTH+7)/8)*8;
  // Tag: ycase(2) xneg(1) zneg(1) azimuth cordic angle later joined
  localparam int unsigned TAGW = 4;

  logic en;
  logic [LAT:0] vld_q;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-1:0], s_axis_tvalid};
    end
  end
  assign m_axis_tvalid = vld_q[LAT];

  logic signed [CW-1:0] x, y, z;
  assign x = s_axis_tdata[CW-1:0];
  assign y = s_axis_tdata[2*CW-1:CW];
  assign z = s_axis_tdata[3*CW-1:2*CW];

  // Stage 0: magnitudes and flags.
  logic [31:0] ax_q, ay_q, az_q;
  logic [3:0]  fl_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q <= 32'(x[CW-1] ? -33'(x) : 33'(x));
      ay_q <= 32'(y[CW-1] ? -33'(y) : 33'(y));
      az_q <= 32'(z[CW-1] ? -33'(z) : 33'(z));
      fl_q <= {(y == '0), y[CW-1], x[CW-1], z[CW-1]};
    end
  end

  // Stage 1: sum of the x and y squares and left shift of all operands (each square one multiplier).
  logic [63:0] ssq_q;
  logic [31:0] az1_q, ax1_q, ay1_q;
  logic [3:0]  fl1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ssq_q <= (64'(ax_q) * 64'(ax_q) + 64'(ay_q) * 64'(ay_q)) << (2*LSH);
      az1_q <= 32'(az_q << LSH);
      ax1_q <= 32'(ax_q << LSH);
      ay1_q <= 32'(ay_q << LSH);
      fl1_q <= fl_q;
    end
  end

  // Square root: one result bit per stage, 32 stages.
  logic [63:0] rem_q [SQ+1];
  logic [31:0] root_q [SQ+1];
  logic [31:0] sx_q [SQ+1], sy_q [SQ+1], sz_q [SQ+1];
  logic [3:0]  sf_q [SQ+1];
  always_comb begin
    rem_q[0] = ssq_q; root_q[0] = '0;
    sx_q[0] = ax1_q; sy_q[0] = ay1_q; sz_q[0] = az1_q; sf_q[0] = fl1_q;
  end
  for (genvar i = 0; i < SQ; i++) begin : g_sqrt
    localparam int unsigned B = SQ - 1 - i;
    logic [65:0] trial;
    assign trial = ({34'd0, root_q[i]} << (B + 1)) + (66'd1 << (2*B));
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (66'(rem_q[i]) >= trial) begin
          rem_q[i+1]  <= rem_q[i] - trial[63:0];
          root_q[i+1] <= root_q[i] | (32'd1 << B);
        end else begin
          rem_q[i+1]  <= rem_q[i];
          root_q[i+1] <= root_q[i];
        end
        sx_q[i+1] <= sx_q[i]; sy_q[i+1] <= sy_q[i];
        sz_q[i+1] <= sz_q[i]; sf_q[i+1] <= sf_q[i];
      end
    end
  end

  // Stage: register CORDIC operands.
  logic [31:0] ca_q, cb_q, pa_q, pb_q;
  logic [3:0]  cf_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ca_q <= sx_q[SQ]; cb_q <= sy_q[SQ];
      pa_q <= sz_q[SQ]; pb_q <= root_q[SQ];
      cf_q <= sf_q[SQ];
    end
  end

  logic [31:0] qa, qp;
  logic [TAGW-1:0] tag_a, tag_p;
  csa_cordic #(.STAGES(CORDIC_STAGES), .TAG_W(TAGW)) u_cordic_az (
    .clk_i, .en_i(en), .a_i(ca_q), .b_i(cb_q), .tag_i(cf_q),
    .ang_o(qa), .tag_o(tag_a)
  );
  csa_cordic #(.STAGES(CORDIC_STAGES), .TAG_W(TAGW)) u_cordic_pol (
    .clk_i, .en_i(en), .a_i(pa_q), .b_i(pb_q), .tag_i(cf_q),
    .ang_o(qp), .tag_o(tag_p)
  );

  logic [31:0] az_ang, pol_ang;
  always_comb begin
    if (tag_a[3]) begin
      az_ang = tag_a[1] ? csa_pkg::HalfTurn : '0;
    end else if (!tag_a[2]) begin
      az_ang = tag_a[1] ? csa_pkg::HalfTurn - qa : qa;
    end else begin
      az_ang = tag_a[1] ? csa_pkg::HalfTurn + qa : 32'(33'h1_0000_0000 - 33'(qa));
    end
    pol_ang = tag_p[0] ? csa_pkg::HalfTurn - qp : qp;
  end

  logic [OUTW-1:0] out_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= OUTW'({ANGLE_WIDTH'(csa_pkg::to_angle(pol_ang, ANGLE_WIDTH)),
                      ANGLE_WIDTH'(csa_pkg::to_angle(az_ang, ANGLE_WIDTH))});
    end
  end
  assign m_axis_tdata = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q)) else $error("pipeline moved during stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while output stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && s_axis_tvalid) |=> vld_q[0]) else $error("accepted beat lost");

endmodule
